[design/csvg_pkg.sv]
// Shared types, constants and face geometry for the cube-sphere vertex generator.
package csvg_pkg;

  localparam int FACE_W     = 3;
  localparam int IDX_W      = 8;
  localparam int N_W        = 8;
  localparam int RAD_W      = 16;
  localparam int OUT_W      = 16;
  localparam int ADDR_W     = 3;
  localparam int C_W        = 9;
  localparam int EXT_W      = 12;
  localparam int MAG_W      = 8;
  localparam int S_W        = 2 * C_W;
  localparam int LEN_FRAC   = 16;
  localparam int ROOT_W     = (S_W + 2 * LEN_FRAC) / 2;
  localparam int PROD_W     = MAG_W + RAD_W;
  localparam int POS_NUM_W  = PROD_W + LEN_FRAC;
  localparam int POS_QW     = RAD_W + 1;
  localparam int UV_FRAC    = 15;
  localparam int TEX_NUM_W  = IDX_W + UV_FRAC;
  localparam int TEX_DEN_W  = N_W + 1;
  localparam int TEX_QW     = UV_FRAC + 1;
  localparam int TEX_LAT    = TEX_QW + 1;
  localparam int SQRT_LAT   = ROOT_W;
  localparam int FRONT_LAT  = 2;

  localparam logic [N_W-1:0]   MAX_SUBDIV    = 8'd255;
  localparam logic [N_W-1:0]   SUBDIV_RESET  = 8'd8;
  localparam logic [RAD_W-1:0] RADIUS_RESET  = 16'd256;
  localparam logic [UV_FRAC:0] UV_ONE        = 16'd32768;
  localparam logic [POS_QW-1:0] POS_MAX      = 17'd32767;
  localparam logic [POS_QW-1:0] NEG_MAX      = 17'd32768;
  localparam logic [OUT_W-1:0] SAT_POS       = 16'h7fff;
  localparam logic [OUT_W-1:0] SAT_NEG       = 16'h8000;

  localparam logic REG_SUBDIV = 1'b0;
  localparam logic REG_RADIUS = 1'b1;

  localparam logic [FACE_W-1:0] FACE_PZ = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PX = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd5;
  localparam logic [FACE_W-1:0] FACE_LAST = FACE_NX;

  typedef logic [1:0] dir_t;
  localparam dir_t DIR_Z = 2'b00;
  localparam dir_t DIR_P = 2'b01;
  localparam dir_t DIR_N = 2'b11;

  // index 0 is x, 1 is y, 2 is z
  typedef struct packed {
    dir_t [2:0] start;
    dir_t [2:0] lat;
    dir_t [2:0] lon;
  } geom_t;

  typedef struct packed {
    logic [S_W-1:0]             s;
    logic [2:0][MAG_W-1:0]      mag;
    logic [2:0]                 neg;
    logic [2:0][PROD_W-1:0]     prod;
    logic                       oor;
    logic [IDX_W-1:0]           col;
    logic [IDX_W-1:0]           row;
    logic [TEX_DEN_W-1:0]       np1;
  } front_t;

  function automatic geom_t face_geom(input logic [FACE_W-1:0] face);
    geom_t g;
    g = '0;
    case (face)
      FACE_PZ: begin
        g.start = {DIR_P, DIR_P, DIR_N};
        g.lat   = {DIR_Z, DIR_Z, DIR_P};
        g.lon   = {DIR_Z, DIR_N, DIR_Z};
      end
      FACE_NZ: begin
        g.start = {DIR_N, DIR_P, DIR_P};
        g.lat   = {DIR_Z, DIR_Z, DIR_N};
        g.lon   = {DIR_Z, DIR_N, DIR_Z};
      end
      FACE_PY: begin
        g.start = {DIR_N, DIR_P, DIR_N};
        g.lat   = {DIR_Z, DIR_Z, DIR_P};
        g.lon   = {DIR_P, DIR_Z, DIR_Z};
      end
      FACE_NY: begin
        g.start = {DIR_N, DIR_N, DIR_P};
        g.lat   = {DIR_Z, DIR_Z, DIR_N};
        g.lon   = {DIR_P, DIR_Z, DIR_Z};
      end
      FACE_PX: begin
        g.start = {DIR_P, DIR_P, DIR_P};
        g.lat   = {DIR_N, DIR_Z, DIR_Z};
        g.lon   = {DIR_Z, DIR_N, DIR_Z};
      end
      FACE_NX: begin
        g.start = {DIR_N, DIR_P, DIR_N};
        g.lat   = {DIR_P, DIR_Z, DIR_Z};
        g.lon   = {DIR_Z, DIR_N, DIR_Z};
      end
      default: g = '0;
    endcase
    return g;
  endfunction

  function automatic logic signed [EXT_W-1:0] apply_dir(input dir_t d,
                                                        input logic [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] r;
    case (d)
      DIR_P:   r = $signed(v);
      DIR_N:   r = -$signed(v);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[design/csvg_front.sv]
// Front stages: face geometry, cube point, squared length, radius product, range check.
module csvg_front (
  input  logic                            clk,
  input  logic                            en,
  input  logic [csvg_pkg::FACE_W-1:0]     face,
  input  logic [csvg_pkg::IDX_W-1:0]      col,
  input  logic [csvg_pkg::IDX_W-1:0]      row,
  input  logic [csvg_pkg::N_W-1:0]        subdiv,
  input  logic [csvg_pkg::RAD_W-1:0]      radius,
  output csvg_pkg::front_t                fr
);

  localparam int EXT_W = csvg_pkg::EXT_W;
  localparam int C_W   = csvg_pkg::C_W;
  localparam int S_W   = csvg_pkg::S_W;

  logic [csvg_pkg::N_W-1:0]           n_eff;
  csvg_pkg::geom_t                    g;
  logic signed [EXT_W-1:0]            c_ext [3];
  logic signed [C_W-1:0]              c_nxt [3];
  logic signed [C_W-1:0]              c_r   [3];
  logic                               oor_nxt;
  logic                               oor_r;
  logic [csvg_pkg::IDX_W-1:0]         col_r;
  logic [csvg_pkg::IDX_W-1:0]         row_r;
  logic [csvg_pkg::N_W-1:0]           n_r;
  csvg_pkg::front_t                   fr_nxt;
  csvg_pkg::front_t                   fr_r;
  logic signed [2*C_W-1:0]            sq [3];
  logic signed [C_W-1:0]              cneg [3];

  always_comb begin
    if (subdiv == '0) begin
      n_eff = csvg_pkg::N_W'(1);
    end else if (subdiv > csvg_pkg::MAX_SUBDIV) begin
      n_eff = csvg_pkg::MAX_SUBDIV;
    end else begin
      n_eff = subdiv;
    end
    g = csvg_pkg::face_geom(face);
    for (int k = 0; k < 3; k++) begin
      c_ext[k] = csvg_pkg::apply_dir(g.start[k], EXT_W'(n_eff))
               + csvg_pkg::apply_dir(g.lat[k], EXT_W'({col, 1'b0}))
               + csvg_pkg::apply_dir(g.lon[k], EXT_W'({row, 1'b0}));
      c_nxt[k] = c_ext[k][C_W-1:0];
    end
    oor_nxt = (face > csvg_pkg::FACE_LAST) || (col > n_eff) || (row > n_eff);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c_r[k] <= c_nxt[k];
      end
      oor_r <= oor_nxt;
      col_r <= col;
      row_r <= row;
      n_r   <= n_eff;
    end
  end

  always_comb begin
    fr_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      sq[k]          = (2*C_W)'(c_r[k]) * (2*C_W)'(c_r[k]);
      cneg[k]        = -c_r[k];
      fr_nxt.neg[k]  = c_r[k][C_W-1];
      fr_nxt.mag[k]  = c_r[k][C_W-1] ? cneg[k][csvg_pkg::MAG_W-1:0]
                                     : c_r[k][csvg_pkg::MAG_W-1:0];
      fr_nxt.prod[k] = csvg_pkg::PROD_W'(fr_nxt.mag[k]) * csvg_pkg::PROD_W'(radius);
    end
    fr_nxt.s   = S_W'(unsigned'(sq[0])) + S_W'(unsigned'(sq[1]))
               + S_W'(unsigned'(sq[2]));
    fr_nxt.oor = oor_r;
    fr_nxt.col = col_r;
    fr_nxt.row = row_r;
    fr_nxt.np1 = csvg_pkg::TEX_DEN_W'(n_r) + csvg_pkg::TEX_DEN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fr_r <= fr_nxt;
    end
  end

  assign fr = fr_r;

endmodule

[design/csvg_sqrt.sv]
// Pipelined integer square root of the squared length shifted left by 2*LEN_FRAC, one result bit per stage.
module csvg_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [csvg_pkg::S_W-1:0]       s,
  output logic [csvg_pkg::ROOT_W-1:0]    len
);

  localparam int S_W    = csvg_pkg::S_W;
  localparam int ROOT_W = csvg_pkg::ROOT_W;
  localparam int X_W    = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;

  logic [S_W-1:0]    s_r    [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [S_W-1:0]    s_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_in;
    logic [X_W-1:0]    xw;
    logic [REM_W-1:0]  cand;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign s_in    = s;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign s_in    = s_r[k-1];
      assign root_in = root_r[k-1];
      assign rem_in  = rem_r[k-1];
    end

    assign xw    = X_W'(s_in) << (2 * csvg_pkg::LEN_FRAC);
    assign cand  = {rem_in[REM_W-3:0], xw[2*(ROOT_W-1-k)+1 -: 2]};
    assign trial = REM_W'({root_in, 2'b01});
    assign ge    = cand >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k]    <= s_in;
        rem_r[k]  <= ge ? (cand - trial) : cand;
        root_r[k] <= {root_in[ROOT_W-2:0], ge};
      end
    end
  end

  assign len = root_r[ROOT_W-1];

endmodule

[design/csvg_div.sv]
// Pipelined restoring divider with round-to-nearest, one quotient bit per stage.
module csvg_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 25,
  parameter int Q_W   = 17,
  parameter int LAT   = 18
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  localparam int D_W = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;
  localparam int PAD = LAT - Q_W - 1;

  logic [D_W-1:0]   d_r;
  logic [DEN_W-1:0] den0_r;
  logic [D_W-1:0]   dsh;
  logic [DEN_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]   low_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= D_W'(num) + D_W'(den >> 1);
      den0_r <= den;
    end
  end

  assign dsh = d_r >> Q_W;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [Q_W-1:0]   low_in;
    logic [Q_W-1:0]   q_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   cand;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = dsh[DEN_W-1:0];
      assign low_in = d_r[Q_W-1:0];
      assign q_in   = '0;
      assign den_in = den0_r;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign cand = {rem_in, low_in[Q_W-1]};
    assign ge   = cand >= {1'b0, den_in};
    assign diff = cand - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
        low_r[k] <= low_in << 1;
        q_r[k]   <= {q_in[Q_W-2:0], ge};
        den_r[k] <= den_in;
      end
    end
  end

  if (PAD > 0) begin : g_pad
    logic [Q_W-1:0] pad_r [PAD];
    always_ff @(posedge clk) begin
      if (en) begin
        pad_r[0] <= q_r[Q_W-1];
        for (int i = 1; i < PAD; i++) begin
          pad_r[i] <= pad_r[i-1];
        end
      end
    end
    assign quo = pad_r[PAD-1];
  end else begin : g_nopad
    assign quo = q_r[Q_W-1];
  end

endmodule

[design/csvg_dly.sv]
// Stall-aware delay line that keeps side data aligned with the arithmetic stages.
module csvg_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

[design/cube_sphere_vertex_generator_top.sv]
// Cube-sphere vertex generator: the front stages, the square root, the dividers and the output
// register lie between input transfer and result.
// Throughput one item per cycle; the whole pipeline holds while the output register
// holds an untaken result, so the input and output stall together.
// Synchronous active-low reset clears valid bits and sets subdivisions to 8 and
// radius to 256; payload registers are not reset.
module cube_sphere_vertex_generator_top #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // face[2:0], col[10:3], row[18:11]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, 16 bits each from bit 0
  output logic [127:0]                  out_tdata,
  output logic                          out_tuser,  // out_of_range
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [csvg_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int NORM_NUM_W = csvg_pkg::MAG_W + NORMAL_FRAC_BITS + csvg_pkg::LEN_FRAC;
  localparam int NORM_QW    = NORMAL_FRAC_BITS + 1;
  localparam int DIV_LAT    = ((csvg_pkg::POS_QW > NORM_QW) ? csvg_pkg::POS_QW : NORM_QW) + 1;
  localparam int PIPE_LAT   = csvg_pkg::FRONT_LAT + csvg_pkg::SQRT_LAT + DIV_LAT;
  localparam int TAIL_LAT   = csvg_pkg::SQRT_LAT + DIV_LAT;
  localparam int MAG_W      = csvg_pkg::MAG_W;
  localparam int PROD_W     = csvg_pkg::PROD_W;
  localparam int OUT_W      = csvg_pkg::OUT_W;
  localparam int TEX_QW     = csvg_pkg::TEX_QW;

  logic                         en;
  logic [csvg_pkg::N_W-1:0]     subdiv_r;
  logic [csvg_pkg::RAD_W-1:0]   radius_r;
  logic                         cfg_wr;
  logic [PIPE_LAT-1:0]          vld_r;
  logic                         out_valid_r;
  logic [127:0]                 out_data_r;
  logic                         out_oor_r;
  csvg_pkg::front_t             fr;
  logic [csvg_pkg::ROOT_W-1:0]  len;
  logic [2:0][MAG_W-1:0]        mag_d;
  logic [2:0][PROD_W-1:0]       prod_d;
  logic [2:0]                   neg_d;
  logic                         oor_d;
  logic [csvg_pkg::POS_QW-1:0]  pos_q  [3];
  logic [NORM_QW-1:0]           norm_q [3];
  logic [TEX_QW-1:0]            u_q;
  logic [TEX_QW-1:0]            v_q;
  logic [TEX_QW-1:0]            u_d;
  logic [TEX_QW-1:0]            v_d;
  logic [127:0]                 out_data_nxt;
  logic [OUT_W-1:0]             pos_v  [3];
  logic [OUT_W-1:0]             norm_v [3];
  logic [31:0]                  norm_w [3];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subdiv_r <= csvg_pkg::SUBDIV_RESET;
      radius_r <= csvg_pkg::RADIUS_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        csvg_pkg::REG_SUBDIV: subdiv_r <= cfg_pwdata[csvg_pkg::N_W-1:0];
        csvg_pkg::REG_RADIUS: radius_r <= cfg_pwdata[csvg_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      csvg_pkg::REG_SUBDIV: cfg_prdata = 32'(subdiv_r);
      csvg_pkg::REG_RADIUS: cfg_prdata = 32'(radius_r);
      default:              cfg_prdata = '0;
    endcase
  end

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[PIPE_LAT-2:0], in_tvalid};
      out_valid_r <= vld_r[PIPE_LAT-1];
    end
  end

  csvg_front u_front (
    .clk    (clk),
    .en     (en),
    .face   (in_tdata[2:0]),
    .col    (in_tdata[10:3]),
    .row    (in_tdata[18:11]),
    .subdiv (subdiv_r),
    .radius (radius_r),
    .fr     (fr)
  );

  csvg_sqrt u_sqrt (
    .clk (clk),
    .en  (en),
    .s   (fr.s),
    .len (len)
  );

  csvg_dly #(.W(3 * (MAG_W + PROD_W)), .DEPTH(csvg_pkg::SQRT_LAT)) u_dly_mag (
    .clk (clk),
    .en  (en),
    .d   ({fr.mag, fr.prod}),
    .q   ({mag_d, prod_d})
  );

  csvg_dly #(.W(4), .DEPTH(TAIL_LAT)) u_dly_sign (
    .clk (clk),
    .en  (en),
    .d   ({fr.neg, fr.oor}),
    .q   ({neg_d, oor_d})
  );

  for (genvar k = 0; k < 3; k++) begin : g_axis
    csvg_div #(
      .NUM_W (csvg_pkg::POS_NUM_W),
      .DEN_W (csvg_pkg::ROOT_W),
      .Q_W   (csvg_pkg::POS_QW),
      .LAT   (DIV_LAT)
    ) u_div_pos (
      .clk (clk),
      .en  (en),
      .num (csvg_pkg::POS_NUM_W'(prod_d[k]) << csvg_pkg::LEN_FRAC),
      .den (len),
      .quo (pos_q[k])
    );

    csvg_div #(
      .NUM_W (NORM_NUM_W),
      .DEN_W (csvg_pkg::ROOT_W),
      .Q_W   (NORM_QW),
      .LAT   (DIV_LAT)
    ) u_div_norm (
      .clk (clk),
      .en  (en),
      .num (NORM_NUM_W'(mag_d[k]) << (NORMAL_FRAC_BITS + csvg_pkg::LEN_FRAC)),
      .den (len),
      .quo (norm_q[k])
    );
  end

  csvg_div #(
    .NUM_W (csvg_pkg::TEX_NUM_W),
    .DEN_W (csvg_pkg::TEX_DEN_W),
    .Q_W   (TEX_QW),
    .LAT   (csvg_pkg::TEX_LAT)
  ) u_div_u (
    .clk (clk),
    .en  (en),
    .num (csvg_pkg::TEX_NUM_W'(fr.col) << csvg_pkg::UV_FRAC),
    .den (fr.np1),
    .quo (u_q)
  );

  csvg_div #(
    .NUM_W (csvg_pkg::TEX_NUM_W),
    .DEN_W (csvg_pkg::TEX_DEN_W),
    .Q_W   (TEX_QW),
    .LAT   (csvg_pkg::TEX_LAT)
  ) u_div_v (
    .clk (clk),
    .en  (en),
    .num (csvg_pkg::TEX_NUM_W'(fr.row) << csvg_pkg::UV_FRAC),
    .den (fr.np1),
    .quo (v_q)
  );

  csvg_dly #(.W(2 * TEX_QW), .DEPTH(TAIL_LAT - csvg_pkg::TEX_LAT)) u_dly_tex (
    .clk (clk),
    .en  (en),
    .d   ({u_q, v_q}),
    .q   ({u_d, v_d})
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (neg_d[k]) begin
        pos_v[k] = (pos_q[k] > csvg_pkg::NEG_MAX) ? csvg_pkg::SAT_NEG
                                                  : OUT_W'(-pos_q[k]);
      end else begin
        pos_v[k] = (pos_q[k] > csvg_pkg::POS_MAX) ? csvg_pkg::SAT_POS
                                                  : pos_q[k][OUT_W-1:0];
      end
      norm_w[k] = neg_d[k] ? (32'd0 - 32'(norm_q[k])) : 32'(norm_q[k]);
      norm_v[k] = norm_w[k][OUT_W-1:0];
    end
    out_data_nxt = {
      OUT_W'(csvg_pkg::UV_ONE - (TEX_QW + 1)'(v_d)),
      u_d[OUT_W-1:0],
      norm_v[2], norm_v[1], norm_v[0],
      pos_v[2], pos_v[1], pos_v[0]
    };
    if (oor_d) begin
      out_data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_oor_r  <= oor_d;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_oor_r;

endmodule
